// ===== src/crc32r_pkg.sv =====
// ----------------------------------------------------------------------------
// crc32r_pkg
// Shared types, constants and the nibble remainder table for the reflected
// CRC-32 byte stream block.
// ----------------------------------------------------------------------------
`default_nettype none

package crc32r_pkg;

  localparam int unsigned CRC_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned NIB_W  = 4;

  typedef logic [CRC_W-1:0]  crc_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [NIB_W-1:0]  nib_t;

  localparam crc_t INIT_RESET_VALUE = 32'hC111_8510;

  // reflected remainders of polynomial 0xedb88320 for each 4-bit value
  function automatic crc_t nibble_rem(input nib_t n);
    crc_t r;
    case (n)
      4'h0:    r = 32'h0000_0000;
      4'h1:    r = 32'h1DB7_1064;
      4'h2:    r = 32'h3B6E_20C8;
      4'h3:    r = 32'h26D9_30AC;
      4'h4:    r = 32'h76DC_4190;
      4'h5:    r = 32'h6B6B_51F4;
      4'h6:    r = 32'h4DB2_6158;
      4'h7:    r = 32'h5005_713C;
      4'h8:    r = 32'hEDB8_8320;
      4'h9:    r = 32'hF00F_9344;
      4'hA:    r = 32'hD6D6_A3E8;
      4'hB:    r = 32'hCB61_B38C;
      4'hC:    r = 32'h9B64_C2B0;
      4'hD:    r = 32'h86D3_D2D4;
      4'hE:    r = 32'hA00A_E278;
      4'hF:    r = 32'hBDBD_F21C;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic crc_t advance_nibble(input crc_t v);
    return (v >> NIB_W) ^ nibble_rem(v[NIB_W-1:0]);
  endfunction

endpackage

`default_nettype wire

// ===== src/crc32_reflected_byte_stream.sv =====
// ----------------------------------------------------------------------------
// crc32_reflected_byte_stream
// Reflected CRC-32 (poly 0xedb88320, no final xor) over a byte stream.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while in_ready is high. Each byte is folded into
// a 32-bit running crc in the same cycle it is transferred; the byte flagged
// last_byte produces one crc_value and reloads the running crc from
// init_value (0xc1118510 after reset). The result passes through a two-entry
// output buffer, so input ready drops only while both entries hold results
// waiting downstream. Throughput is one byte per clock while in_ready is
// high; the crc is registered in the output buffer before it appears on
// crc_value. Write init_value only in a cycle with no byte transfer; a write
// leaves an open message alone and takes effect at the next reload.
`default_nettype none

module crc32_reflected_byte_stream (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_write_en,
  input  wire  [31:0] cfg_write_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  data_byte,
  input  wire         last_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] crc_value
);
  import crc32r_pkg::*;

  crc_t init_value;
  crc_t running_crc;
  crc_t folded;
  logic accept;
  logic space;

  assign in_ready = space;
  assign accept   = in_valid && space;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_value <= INIT_RESET_VALUE;
    end else if (cfg_write_en) begin
      init_value <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= INIT_RESET_VALUE;
    end else if (accept) begin
      running_crc <= last_byte ? init_value : folded;
    end
  end

  crc32r_fold u_fold (
    .crc_in  (running_crc),
    .data_in (data_byte),
    .crc_out (folded)
  );

  crc32r_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && last_byte),
    .push_data (folded),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (crc_value)
  );

endmodule

`default_nettype wire

// ===== src/crc32r_fold.sv =====
// ----------------------------------------------------------------------------
// crc32r_fold
// Folds one byte into the running CRC: xor into the low byte, then two
// table-driven nibble steps.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32r_fold (
  input  var crc32r_pkg::crc_t  crc_in,
  input  var crc32r_pkg::byte_t data_in,
  output var crc32r_pkg::crc_t  crc_out
);
  import crc32r_pkg::*;

  crc_t mixed;
  crc_t step1;

  always_comb begin
    mixed   = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
    step1   = advance_nibble(mixed);
    crc_out = advance_nibble(step1);
  end

endmodule

`default_nettype wire

// ===== src/crc32r_skid.sv =====
// ----------------------------------------------------------------------------
// crc32r_skid
// Two-entry result buffer: an output register plus a skid stage, so the
// input side keeps moving while a finished crc waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32r_skid (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  var crc32r_pkg::crc_t push_data,
  output logic             space,
  output logic             out_valid,
  input  wire              out_ready,
  output var crc32r_pkg::crc_t out_data
);
  import crc32r_pkg::*;

  logic main_valid;
  crc_t main_data;
  logic skid_valid;
  crc_t skid_data;

  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      // output slot frees this cycle
      if (skid_valid) begin
        main_valid <= 1'b1;
        main_data  <= skid_data;
        skid_valid <= push;
        if (push) begin
          skid_data <= push_data;
        end
      end else begin
        main_valid <= push;
        if (push) begin
          main_data <= push_data;
        end
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== tb/crc32_stream_checker.sv =====
// ----------------------------------------------------------------------------
// crc32_stream_checker
// Watches the byte and result channels of the reflected CRC-32 block, keeps
// its own running CRC and init register, and compares every finished CRC
// against the oldest one it predicted.
// ----------------------------------------------------------------------------
module crc32_stream_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_write_en,
  input  wire  [31:0] cfg_write_data,
  input  wire         in_valid,
  input  wire         in_ready,
  input  wire  [7:0]  data_byte,
  input  wire         last_byte,
  input  wire         out_valid,
  input  wire         out_ready,
  input  wire  [31:0] crc_value,
  output int          fail_count,
  output int          results_due
);
  import crc32r_pkg::*;

  localparam crc_t REFLECTED_POLY = 32'hEDB8_8320;
  localparam int   REPORT_LIMIT   = 10;

  crc_t init_reg    = INIT_RESET_VALUE;
  crc_t running_crc = INIT_RESET_VALUE;
  crc_t crc_expected [$];
  int   mismatches  = 0;

  // eight single-bit reflected shifts per byte
  function automatic crc_t fold_in(input crc_t acc, input byte_t b);
    crc_t v;
    v = acc ^ crc_t'(b);
    for (int i = 0; i < BYTE_W; i++) begin
      v = v[0] ? ((v >> 1) ^ REFLECTED_POLY) : (v >> 1);
    end
    return v;
  endfunction

  always @(posedge clk) begin
    crc_t want;
    crc_t next_crc;
    if (rst) begin
      init_reg    = INIT_RESET_VALUE;
      running_crc = INIT_RESET_VALUE;
      crc_expected.delete();
    end else begin
      // results first, so a byte transferred on the same edge cannot hide a stray result
      if (out_valid && out_ready) begin
        if (crc_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: crc_value %h transferred with no message finished", $realtime,
                     crc_value);
        end else begin
          want = crc_expected.pop_front();
          if (crc_value !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: crc_value mismatch: expected %h, actual %h", $realtime, want,
                       crc_value);
          end
        end
      end
      if (in_valid && in_ready) begin
        next_crc = fold_in(running_crc, data_byte);
        if (last_byte) begin
          crc_expected.push_back(next_crc);
          running_crc = init_reg;
        end else begin
          running_crc = next_crc;
        end
      end
      // a new init value only shows at the next reload
      if (cfg_write_en) init_reg = cfg_write_data;
    end
    fail_count  <= mismatches;
    results_due <= crc_expected.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the reflected CRC-32 byte stream block: directed messages,
// an init change in the middle of a message, then random messages over four
// phases of sender gaps and receiver stalls, each with its own init value.
// ----------------------------------------------------------------------------
module tb;
  import crc32r_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_ITEMS    = 325;

  logic  clk            = 1'b0;
  logic  rst            = 1'b1;
  logic  cfg_write_en   = 1'b0;
  crc_t  cfg_write_data = '0;
  logic  in_valid       = 1'b0;
  byte_t data_byte      = '0;
  logic  last_byte      = 1'b0;
  logic  out_ready      = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire [31:0] crc_value;

  int fail_count;
  int results_due;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int bytes_sent     = 0;

  always #5 clk = ~clk;

  crc32_reflected_byte_stream i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .crc_value      (crc_value)
  );

  crc32_stream_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .crc_value      (crc_value),
    .fail_count     (fail_count),
    .results_due    (results_due)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called and returns at a falling edge; valid stays up after the transfer
  task automatic send_byte(input byte_t b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(byte_t'($urandom), i == len - 1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic write_init(input crc_t v);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  initial begin
    crc_t phase_init [4];
    int   idle_pct [4];
    int   stall_pct [4];
    int   phase_end;
    int   len;
    phase_init = '{INIT_RESET_VALUE, crc_t'($urandom), 32'h0000_0000, 32'hFFFF_FFFF};
    idle_pct   = '{0, 56, 0, 10};
    stall_pct  = '{0, 0, 56, 10};

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single-byte messages at the data extremes, from the reset init value
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // the usual check string "123456789"
    for (int i = 0; i < 9; i++) send_byte(byte_t'(8'h31 + i), i == 8);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    // init changed with a message open: this message keeps its running crc
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    write_init(32'h0000_0000);
    send_byte(8'h56, 1'b1);
    send_byte(8'hFF, 1'b1);
    write_init(32'hFFFF_FFFF);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);

    for (int p = 0; p < 4; p++) begin
      write_init(phase_init[p]);
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      phase_end      = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < phase_end) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
        send_message(len);
        // now and then hold the sender until the result side has caught up
        if ($urandom_range(24) == 0) drain();
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
